### hdl/packed_pattern_parser_top_macros.svh
// Assertion macros shared by the packed pattern parser modules.
`ifndef PACKED_PATTERN_PARSER_TOP_MACROS_SVH
`define PACKED_PATTERN_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PPP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ppp_pkg.sv
// Package for the packed pattern parser: result types, constants, note conversion.
`timescale 1ns / 1ps

package ppp_pkg;

    localparam int PPP_ROWS_DEFAULT = 64;
    localparam int CFG_W            = 6;
    localparam logic [CFG_W-1:0] CHANNELS_RESET = 6'd32;
    localparam logic [7:0] NO_NOTE  = 8'hFF;

    // Packed so that the first field sits in the highest bits.
    typedef struct packed {
        logic [7:0] info;
        logic [7:0] command;
        logic       command_valid;
        logic [7:0] volume;
        logic       volume_valid;
        logic [7:0] instrument;
        logic       instrument_valid;
        logic [7:0] note_value;
        logic       note_valid;
        logic [5:0] row;
        logic [4:0] channel;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   kind;     // 0 note entry, 1 end of pattern
        t_entry entry;
    } t_result;

    // octave/semitone byte to linear note: (oct-2)*12 + semi + 1, wraps at 8 bits
    function automatic logic [7:0] note_convert(input logic [7:0] b);
        logic [7:0] oct;
        oct = {4'd0, b[7:4]};
        return (oct << 3) + (oct << 2) + {4'd0, b[3:0]} + 8'd1 - 8'd24;
    endfunction

endpackage

### hdl/ppp_core.sv
// Packed pattern byte parser: phase, row count and entry holds.
`timescale 1ns / 1ps

module ppp_core import ppp_pkg::*; #(
    parameter int ROWS_PER_PATTERN = PPP_ROWS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_pattern_start,
    input  logic [CFG_W-1:0] i_channel_count,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam logic [5:0] LastRow = 6'(ROWS_PER_PATTERN - 1);

    localparam logic [2:0] PH_FLAG  = 3'd0;
    localparam logic [2:0] PH_NOTE  = 3'd1;
    localparam logic [2:0] PH_INSTR = 3'd2;
    localparam logic [2:0] PH_VOL   = 3'd3;
    localparam logic [2:0] PH_CMD   = 3'd4;
    localparam logic [2:0] PH_INFO  = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [5:0] r_row, n_row;
    logic [7:0] r_flag, n_flag;
    logic [7:0] r_note, n_note;
    logic [7:0] r_instr, n_instr;
    logic [7:0] r_vol, n_vol;
    logic [7:0] r_cmd, n_cmd;
    logic       r_note_seen, n_note_seen;

    logic [2:0] eff_phase;
    logic [5:0] eff_row;
    logic       emit_entry, emit_end;
    logic [7:0] info_byte;
    logic [4:0] ch;

    always_comb begin
        n_phase     = r_phase;
        n_row       = r_row;
        n_flag      = r_flag;
        n_note      = r_note;
        n_instr     = r_instr;
        n_vol       = r_vol;
        n_cmd       = r_cmd;
        n_note_seen = r_note_seen;
        emit_entry  = 1'b0;
        emit_end    = 1'b0;
        info_byte   = 8'd0;
        ch          = 5'd0;
        o_res       = '0;

        // pattern start forces the flag phase at row 0; stray codes read as flag
        eff_phase = (i_pattern_start || r_phase > PH_INFO) ? PH_FLAG : r_phase;
        eff_row   = i_pattern_start ? 6'd0 : r_row;

        if (i_accept) begin
            n_phase = eff_phase;
            n_row   = eff_row;
            case (eff_phase)
                PH_NOTE: begin
                    n_note_seen = (i_data_byte != NO_NOTE);
                    n_note      = n_note_seen ? note_convert(i_data_byte) : 8'd0;
                    n_phase     = PH_INSTR;
                end
                PH_INSTR: begin
                    n_instr = i_data_byte;
                    if (r_flag[6]) begin
                        n_phase = PH_VOL;
                    end else if (r_flag[7]) begin
                        n_phase = PH_CMD;
                    end else begin
                        emit_entry = 1'b1;
                    end
                end
                PH_VOL: begin
                    n_vol = i_data_byte;
                    if (r_flag[7]) begin
                        n_phase = PH_CMD;
                    end else begin
                        emit_entry = 1'b1;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_data_byte;
                    n_phase = PH_INFO;
                end
                PH_INFO: begin
                    info_byte  = i_data_byte;
                    emit_entry = 1'b1;
                end
                default: begin
                    if (i_data_byte == 8'd0) begin
                        // row end
                        if (eff_row >= LastRow) begin
                            emit_end = 1'b1;
                            n_row    = 6'd0;
                        end else begin
                            n_row = eff_row + 6'd1;
                        end
                    end else begin
                        n_flag      = i_data_byte;
                        n_note      = 8'd0;
                        n_note_seen = 1'b0;
                        n_instr     = 8'd0;
                        n_vol       = 8'd0;
                        n_cmd       = 8'd0;
                        if (i_data_byte[5]) begin
                            n_phase = PH_NOTE;
                        end else if (i_data_byte[6]) begin
                            n_phase = PH_VOL;
                        end else if (i_data_byte[7]) begin
                            n_phase = PH_CMD;
                        end else begin
                            emit_entry = 1'b1;   // bare flag
                        end
                    end
                end
            endcase
        end

        if (emit_entry) begin
            n_phase = PH_FLAG;
            ch = ({1'b0, n_flag[4:0]} >= i_channel_count) ? 5'd0 : n_flag[4:0];
            o_res.kind                   = 1'b0;
            o_res.entry.channel          = ch;
            o_res.entry.row              = eff_row;
            o_res.entry.note_valid       = n_flag[5] & n_note_seen;
            o_res.entry.note_value       = (n_flag[5] & n_note_seen) ? n_note : 8'd0;
            o_res.entry.instrument_valid = n_flag[5];
            o_res.entry.instrument       = n_flag[5] ? n_instr : 8'd0;
            o_res.entry.volume_valid     = n_flag[6];
            o_res.entry.volume           = n_flag[6] ? n_vol : 8'd0;
            o_res.entry.command_valid    = n_flag[7];
            o_res.entry.command          = n_flag[7] ? n_cmd : 8'd0;
            o_res.entry.info             = n_flag[7] ? info_byte : 8'd0;
        end else if (emit_end) begin
            o_res.kind      = 1'b1;
            o_res.entry.row = LastRow;
        end
        o_res_valid = emit_entry | emit_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_row   <= 6'd0;
        end else begin
            r_phase <= n_phase;
            r_row   <= n_row;
        end
    end

    // holds are always loaded by a flag byte before an entry reads them
    always_ff @(posedge i_clk) begin
        r_flag      <= n_flag;
        r_note      <= n_note;
        r_instr     <= n_instr;
        r_vol       <= n_vol;
        r_cmd       <= n_cmd;
        r_note_seen <= n_note_seen;
    end

`include "packed_pattern_parser_top_macros.svh"

    `PPP_ASSERT_IMP(a_phase_legal, 1'b1, r_phase <= PH_INFO, "phase code out of range")
    `PPP_ASSERT_NXT(a_end_clears_row, o_res_valid && o_res.kind, r_row == 6'd0 && r_phase == PH_FLAG, "row not cleared after pattern end")
    `PPP_ASSERT_IMP(a_note_needs_instr, o_res_valid && o_res.entry.note_valid, o_res.entry.instrument_valid, "note without instrument")

endmodule

### hdl/packed_pattern_parser_top.sv
// Top level of the packed pattern parser: config register, parser core, output skid.
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit first)                         tuser
// s_axis    in   data_byte[7:0]                                 pattern_start
// m_axis    out  channel, row, note_valid, note_value,          kind
//                instrument_valid, instrument, volume_valid,
//                volume, command_valid, command, info, 1 pad bit
// cfg       in   i_cfg_wdata = channel_count, written when i_cfg_we
//
// One byte per cycle while the output stage has room; the result of the byte that
// completes an entry or ends the last row is registered into the output stage.
// The phase register and row counter form the parser's loop. A two-entry output
// stage (result register plus skid) keeps s_axis_tready high while one result
// waits, so the input stalls only when both entries are full. Reset is synchronous,
// active low, and clears phase, row, channel count (to 32) and the output stage.

module packed_pattern_parser_top import ppp_pkg::*; #(
    parameter int ROWS_PER_PATTERN = PPP_ROWS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,     // channel_count
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,    // data_byte
    input  logic             s_axis_tuser,    // pattern_start
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [55:0]      m_axis_tdata,    // channel .. info, see table above
    output logic             m_axis_tuser     // kind
);

    logic [CFG_W-1:0] r_channel_count;
    logic             r_out_valid, r_skid_valid;
    t_result          r_out, r_skid;
    logic             accept, pop, res_valid;
    t_result          res;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    ppp_core #(
        .ROWS_PER_PATTERN (ROWS_PER_PATTERN)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (s_axis_tdata),
        .i_pattern_start (s_axis_tuser),
        .i_channel_count (r_channel_count),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNELS_RESET;
        end else if (i_cfg_we) begin
            r_channel_count <= i_cfg_wdata;
        end
    end

    // output stage: skid only fills when the result register is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (accept && res_valid) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.entry};
    assign m_axis_tuser  = r_out.kind;

`include "packed_pattern_parser_top_macros.svh"

    `PPP_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid, "skid holds an item ahead of the output")
    `PPP_ASSERT_NXT(a_skid_held, r_skid_valid && !m_axis_tready, r_skid_valid && !s_axis_tready, "skid item lost while stalled")
    `PPP_ASSERT_IMP(a_end_shape, m_axis_tvalid && m_axis_tuser, r_out.entry.channel == 5'd0 && r_out.entry.row == 6'(ROWS_PER_PATTERN - 1), "malformed pattern end")

endmodule

### test/packed_pattern_parser_top_tb.sv
// Self-checking testbench for the packed pattern parser: directed table, random patterns, checker.
`timescale 1ns / 1ps

module packed_pattern_parser_top_tb;
    import ppp_pkg::*;

    localparam int PATTERN_ROWS    = PPP_ROWS_DEFAULT;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 5000;

    typedef enum logic [2:0] {
        ST_FLAG, ST_NOTE, ST_INSTR, ST_VOL, ST_CMD, ST_INFO, ST_DONE
    } t_parse_state;

    // One directed item; res is used only when typed is set (yields = a result is due).
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        logic       yields;
        t_result    res;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [55:0]      m_axis_tdata;
    logic             m_axis_tuser;

    // Parser state as the testbench sees it
    t_parse_state     st_q     = ST_FLAG;
    logic [7:0]       flag_q   = '0;
    logic [7:0]       note_q   = '0;
    logic             note_ok  = 1'b0;
    logic [7:0]       instr_q  = '0;
    logic [7:0]       vol_q    = '0;
    logic [7:0]       cmd_q    = '0;
    logic [5:0]       row_q    = '0;
    logic [CFG_W-1:0] chan_cnt = CHANNELS_RESET;

    t_result     expected_entries [$];
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    logic        pace_on    = 1'b1;
    logic        hold_req   = 1'b0;

    packed_pattern_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // Byte that follows once position 'from' of an entry is done
    function automatic t_parse_state stage_after(logic [7:0] flag, t_parse_state from);
        if (from < ST_NOTE && flag[5]) return ST_NOTE;
        if (from < ST_VOL && flag[6]) return ST_VOL;
        if (from < ST_CMD && flag[7]) return ST_CMD;
        return ST_DONE;
    endfunction

    function automatic t_result close_entry(logic [7:0] info_b);
        t_result r;
        r = '0;
        r.entry.channel = ({1'b0, flag_q[4:0]} >= chan_cnt) ? 5'd0 : flag_q[4:0];
        r.entry.row     = row_q;
        if (flag_q[5]) begin
            r.entry.note_valid       = note_ok;
            r.entry.note_value       = note_ok ? note_q : 8'd0;
            r.entry.instrument_valid = 1'b1;
            r.entry.instrument       = instr_q;
        end
        if (flag_q[6]) begin
            r.entry.volume_valid = 1'b1;
            r.entry.volume       = vol_q;
        end
        if (flag_q[7]) begin
            r.entry.command_valid = 1'b1;
            r.entry.command       = cmd_q;
            r.entry.info          = info_b;
        end
        st_q = ST_FLAG;
        return r;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                      output t_result r);
        t_parse_state nxt;
        r = '0;
        if (start) begin
            row_q = '0;
            st_q  = ST_FLAG;
        end
        case (st_q)
            ST_NOTE: begin
                // octave in the high nibble, semitone in the low one
                note_ok = (b != NO_NOTE);
                note_q  = note_ok ? b[7:4] * 8'd12 + b[3:0] + 8'd1 - 8'd24 : 8'd0;
                st_q    = ST_INSTR;
                return 1'b0;
            end
            ST_INSTR, ST_VOL: begin
                if (st_q == ST_INSTR) instr_q = b;
                else vol_q = b;
                nxt = stage_after(flag_q, st_q);
                if (nxt == ST_DONE) begin
                    r = close_entry(8'd0);
                    return 1'b1;
                end
                st_q = nxt;
                return 1'b0;
            end
            ST_CMD: begin
                cmd_q = b;
                st_q  = ST_INFO;
                return 1'b0;
            end
            ST_INFO: begin
                r = close_entry(b);
                return 1'b1;
            end
            default: ;
        endcase
        // flag position: a zero byte closes the row
        if (b == 8'd0) begin
            if (int'(row_q) + 1 >= PATTERN_ROWS) begin
                r.kind      = 1'b1;
                r.entry.row = 6'(PATTERN_ROWS - 1);
                row_q       = '0;
                return 1'b1;
            end
            row_q = row_q + 6'd1;
            return 1'b0;
        end
        flag_q  = b;
        note_q  = '0;
        note_ok = 1'b0;
        instr_q = '0;
        vol_q   = '0;
        cmd_q   = '0;
        nxt = stage_after(b, ST_FLAG);
        if (nxt == ST_DONE) begin
            r = close_entry(8'd0);
            return 1'b1;
        end
        st_q = nxt;
        return 1'b0;
    endfunction

    function automatic t_result entry_result(
        logic [4:0] ch, logic [5:0] row,
        logic nv, logic [7:0] note, logic iv, logic [7:0] ins,
        logic vv, logic [7:0] vol, logic cv, logic [7:0] cmd, logic [7:0] inf);
        t_result r;
        r = '0;
        r.entry = '{info: inf, command: cmd, command_valid: cv, volume: vol,
                    volume_valid: vv, instrument: ins, instrument_valid: iv,
                    note_value: note, note_valid: nv, row: row, channel: ch};
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = m_axis_tuser;
            got.entry = m_axis_tdata[ENTRY_W-1:0];
            if (expected_entries.size() == 0) begin
                $error("unexpected result: kind %0d channel %0d row %0d",
                       got.kind, got.entry.channel, got.entry.row);
                fail_count++;
            end else begin
                want = expected_entries.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("channel", want.entry.channel, got.entry.channel);
                check_field("row", want.entry.row, got.entry.row);
                check_field("note_valid", want.entry.note_valid, got.entry.note_valid);
                check_field("note_value", want.entry.note_value, got.entry.note_value);
                check_field("instrument_valid", want.entry.instrument_valid,
                            got.entry.instrument_valid);
                check_field("instrument", want.entry.instrument, got.entry.instrument);
                check_field("volume_valid", want.entry.volume_valid, got.entry.volume_valid);
                check_field("volume", want.entry.volume, got.entry.volume);
                check_field("command_valid", want.entry.command_valid,
                            got.entry.command_valid);
                check_field("command", want.entry.command, got.entry.command);
                check_field("info", want.entry.info, got.entry.info);
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Rotating ready pattern with a random reload; bit 0 kept set so it always drains.
    // A hold request turns ready off for a long stretch.
    initial begin : receiver
        logic [15:0] ready_bits;
        int unsigned cyc;
        ready_bits = 16'hFFFF;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (cyc % 64 == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_bits = 16'hFFFF;
                        1:       ready_bits = 16'($urandom) | 16'h0001;
                        2:       ready_bits = 16'($urandom | $urandom) | 16'h0001;
                        default: ready_bits = 16'($urandom & $urandom) | 16'h0001;
                    endcase
                end
                m_axis_tready <= ready_bits[0];
                ready_bits = {ready_bits[0], ready_bits[15:1]};
                cyc++;
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // Offers one item and returns at the edge that accepts it; bursts with random gaps.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        if (pace_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic offer(input logic [7:0] b, input logic start);
        t_result r;
        send_byte(b, start);
        if (parse_byte(b, start, r)) expected_entries.push_back(r);
    endtask

    task automatic send_entry(input logic start);
        logic [7:0] flag;
        flag = {3'($urandom_range(0, 7)), 5'($urandom_range(0, 31))};
        if (flag == 8'd0) flag = 8'h20;
        offer(flag, start);
        if (flag[5]) begin
            offer(($urandom_range(0, 7) == 0) ? NO_NOTE : 8'($urandom), 1'b0);
            offer(8'($urandom), 1'b0);
        end
        if (flag[6]) offer(8'($urandom), 1'b0);
        if (flag[7]) begin
            offer(8'($urandom), 1'b0);
            offer(8'($urandom), 1'b0);
        end
    endtask

    // Mostly full patterns with sparse rows; some cut short, some without a start mark
    task automatic send_pattern();
        logic        fresh;
        int unsigned rows;
        int unsigned entries;
        int unsigned row;
        fresh = ($urandom_range(0, 4) != 0);
        rows  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, PATTERN_ROWS - 1)
                                            : PATTERN_ROWS;
        for (row = 0; row < rows; row++) begin
            entries = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (entries) begin
                send_entry(fresh);
                fresh = 1'b0;
            end
            offer(8'h00, fresh);
            fresh = 1'b0;
        end
    endtask

    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 12);
        repeat (n) offer(8'($urandom), $urandom_range(0, 9) == 0);
    endtask

    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_entries.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        // a row end leaves nothing to wait for, so let the core settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_channel_count(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        chan_cnt   = value;
        burst_left = 0;
    endtask

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        t_stim_row        directed_rows [26];
        logic [CFG_W-1:0] cfg_plan [7];
        t_result          r;
        bit               produced;
        int unsigned      phase_base;

        directed_rows = '{
            // bare flag, top channel, first byte of a pattern
            '{8'h1F, 1'b1, 1'b1, 1'b1, entry_result(5'd31, 6'd0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                    1'b0, 8'h00, 1'b0, 8'h00, 8'h00)},
            '{8'h00, 1'b0, 1'b1, 1'b0, '0},                 // row end, nothing out
            '{8'hFF, 1'b0, 1'b0, 1'b0, '0},                 // every field announced
            '{8'hFF, 1'b0, 1'b0, 1'b0, '0},                 // no-note byte
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},                 // zero bytes are data here
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, 1'b1, entry_result(5'd31, 6'd1, 1'b0, 8'h00, 1'b1, 8'h00,
                                                    1'b1, 8'h00, 1'b1, 8'hFF, 8'hFF)},
            '{8'h20, 1'b0, 1'b0, 1'b0, '0},                 // note + instrument only
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},                 // lowest note, wraps
            '{8'hAB, 1'b0, 1'b0, 1'b0, '0},
            '{8'h41, 1'b0, 1'b0, 1'b0, '0},                 // volume only
            '{8'h80, 1'b0, 1'b0, 1'b0, '0},
            '{8'h82, 1'b0, 1'b0, 1'b0, '0},                 // command only
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
            '{8'hA3, 1'b0, 1'b0, 1'b0, '0},                 // note + command, no volume
            '{8'h9F, 1'b0, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, 1'b0, '0},
            '{8'h13, 1'b0, 1'b0, 1'b0, '0},
            '{8'h37, 1'b0, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, 1'b0, '0},
            '{8'hE0, 1'b0, 1'b0, 1'b0, '0},
            '{8'h45, 1'b0, 1'b0, 1'b0, '0},
            // pattern start in the middle of an entry: taken as a fresh flag
            '{8'h15, 1'b1, 1'b1, 1'b1, entry_result(5'd21, 6'd0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                    1'b0, 8'h00, 1'b0, 8'h00, 8'h00)},
            '{8'h00, 1'b0, 1'b0, 1'b0, '0}
        };
        cfg_plan = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd31, 6'd33, 6'd0};
        cfg_plan[6] = 6'($urandom_range(2, 30));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_byte(directed_rows[k].data, directed_rows[k].start);
            produced = parse_byte(directed_rows[k].data, directed_rows[k].start, r);
            if (directed_rows[k].typed) begin
                if (directed_rows[k].yields) expected_entries.push_back(directed_rows[k].res);
            end else if (produced) begin
                expected_entries.push_back(r);
            end
        end

        foreach (cfg_plan[p]) begin
            write_channel_count(cfg_plan[p]);
            if (p == 1) begin
                // back-to-back bare flags while the receiver holds off: output stage fills
                pace_on  = 1'b0;
                hold_req = 1'b1;
                repeat (PRESSURE_ITEMS) offer({3'b000, 5'($urandom_range(1, 31))}, 1'b0);
                pace_on  = 1'b1;
            end
            phase_base = items_sent;
            while (items_sent - phase_base < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 8) send_pattern();
                else send_noise();
            end
        end

        drain_results();
        if (expected_entries.size() != 0) begin
            $error("%0d expected results never arrived", expected_entries.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
